// ===== sv/mstf2f_pkg.sv =====
// ----------------------------------------------------------------------------
// mstf2f_pkg
// Shared types, constants and track tables for the magnetic stripe F2F encoder.
// ----------------------------------------------------------------------------
package mstf2f_pkg;

  localparam int CHAR_W          = 7;
  localparam int CODE_W          = 7;
  localparam int BIT_IDX_W       = 3;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CODE_W-1:0]    T1_START    = 7'h45;
  localparam logic [CODE_W-1:0]    T2_START    = 7'h1A;
  localparam logic [CODE_W-1:0]    END_CODE    = 7'h1F;
  localparam logic [BIT_IDX_W-1:0] T1_LAST_BIT = 3'd6;
  localparam logic [BIT_IDX_W-1:0] T2_LAST_BIT = 3'd4;

  // One classified character waiting for the serializer.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              two;
    logic              bad;
    logic              with_end;
  } mstf2f_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mstf2f_qstat_t;

  typedef struct packed {
    logic                 active;
    logic                 ph_end;
    logic                 half;
    logic [BIT_IDX_W-1:0] bit_idx;
  } mstf2f_bstat_t;

  // Track one covers 0x20..0x5F: six data bits are the offset from space,
  // and bit 6 makes the count of ones odd.
  function automatic logic [CODE_W-1:0] track_one_code(input logic [CHAR_W-1:0] ch);
    logic [5:0] low;
    logic [CODE_W-1:0] res;
    begin
      low = ch[5:0] ^ 6'h20;
      res = '0;
      if (ch[6:5] == 2'b01 || ch[6:5] == 2'b10) begin
        res = {~(^low), low};
      end
      return res;
    end
  endfunction

  // Track two codes are stored bit reversed.
  function automatic logic [CODE_W-1:0] track_two_code(input logic [CHAR_W-1:0] ch);
    logic [CODE_W-1:0] res;
    begin
      unique case (ch)
        7'h30:   res = 7'h01;
        7'h31:   res = 7'h10;
        7'h32:   res = 7'h08;
        7'h33:   res = 7'h19;
        7'h34:   res = 7'h04;
        7'h35:   res = 7'h15;
        7'h36:   res = 7'h0D;
        7'h37:   res = 7'h1C;
        7'h38:   res = 7'h02;
        7'h39:   res = 7'h13;
        7'h3B:   res = 7'h1A;
        7'h3D:   res = 7'h16;
        7'h3F:   res = 7'h1F;
        default: res = '0;
      endcase
      return res;
    end
  endfunction

endpackage

// ===== sv/mstf2f_front.sv =====
// ----------------------------------------------------------------------------
// mstf2f_front
// Accepts characters, maps them through the selected track table and forms
// queue entries.
// ----------------------------------------------------------------------------
module mstf2f_front (
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mstf2f_pkg::CHAR_W-1:0]  in_character,
  input  logic                           in_first_char,
  input  logic                           in_last_char,
  input  logic                           track_two,
  input  mstf2f_pkg::mstf2f_qstat_t      q_stat,
  output logic                           q_wr,
  output mstf2f_pkg::mstf2f_entry_t      q_wdata
);
  import mstf2f_pkg::*;

  logic [CODE_W-1:0] table_code;

  assign in_stall = q_stat.full;
  assign q_wr     = in_valid && !q_stat.full;

  assign table_code = track_two ? track_two_code(in_character)
                                : track_one_code(in_character);

  always_comb begin
    q_wdata.two      = track_two;
    q_wdata.with_end = in_last_char;
    if (in_first_char) begin
      q_wdata.code = track_two ? T2_START : T1_START;
      q_wdata.bad  = 1'b0;
    end else begin
      q_wdata.code = table_code;
      q_wdata.bad  = (table_code == '0);
    end
  end

endmodule

// ===== sv/mstf2f_queue.sv =====
// ----------------------------------------------------------------------------
// mstf2f_queue
// Small register FIFO between the classifier and the serializer.
// ----------------------------------------------------------------------------
module mstf2f_queue #(
  parameter int DEPTH = mstf2f_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr,
  input  mstf2f_pkg::mstf2f_entry_t wdata,
  input  logic                      rd,
  output mstf2f_pkg::mstf2f_entry_t rdata,
  output mstf2f_pkg::mstf2f_qstat_t stat
);
  import mstf2f_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  mstf2f_entry_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign stat.full  = (cnt_r == DEPTH_CNT);
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = wr && !stat.full;
  assign do_rd      = rd && !stat.empty;
  assign rdata      = mem_r[rptr_r];

  // Pointers wrap at DEPTH only if the user keeps the depth a power of two.
  always_comb begin
    wptr_nxt = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/mstf2f_back.sv =====
// ----------------------------------------------------------------------------
// mstf2f_back
// Serializes queued codes into F2F half cells, one per cycle while the output
// is not stalled, and holds them in the output register.
// ----------------------------------------------------------------------------
module mstf2f_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mstf2f_pkg::mstf2f_entry_t q_rdata,
  input  mstf2f_pkg::mstf2f_qstat_t q_stat,
  output logic                      q_rd,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_coil_level,
  output logic                      out_data_bit,
  output logic                      out_bad_char,
  output logic                      out_run_end,
  output mstf2f_pkg::mstf2f_bstat_t stat
);
  import mstf2f_pkg::*;

  mstf2f_entry_t        ent_r;
  logic                 active_r, ph_r, half_r, coil_r;
  logic [BIT_IDX_W-1:0] bit_r;
  logic                 out_valid_r, level_r, dbit_r, bad_r, rend_r;

  logic                 adv, cell_end, item_end, take, b, level;
  logic [BIT_IDX_W-1:0] last_idx;
  logic [CODE_W-1:0]    cur_code;

  assign adv      = !out_valid_r || !out_stall;
  assign last_idx = ent_r.two ? T2_LAST_BIT : T1_LAST_BIT;
  assign cur_code = ph_r ? END_CODE : ent_r.code;
  assign b        = cur_code[bit_r];
  assign cell_end = half_r && (bit_r == last_idx);
  assign item_end = cell_end && (ph_r || !ent_r.with_end);
  assign take     = adv && (!active_r || item_end) && !q_stat.empty;
  assign q_rd     = take;

  // The coil flips at every cell boundary and once more mid-cell for a one.
  assign level = half_r ? (coil_r ^ b) : ~coil_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      ph_r        <= 1'b0;
      half_r      <= 1'b0;
      bit_r       <= '0;
      coil_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= active_r;
      end
      if (adv && active_r) begin
        coil_r <= level;
      end
      if (take) begin
        active_r <= 1'b1;
        ph_r     <= 1'b0;
        half_r   <= 1'b0;
        bit_r    <= '0;
      end else if (adv && active_r) begin
        half_r <= ~half_r;
        if (cell_end) begin
          bit_r <= '0;
          if (item_end) begin
            active_r <= 1'b0;
            ph_r     <= 1'b0;
          end else begin
            ph_r <= 1'b1;
          end
        end else if (half_r) begin
          bit_r <= bit_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r <= q_rdata;
    end
    if (adv) begin
      level_r <= level;
      dbit_r  <= b;
      bad_r   <= ent_r.bad && !ph_r;
      rend_r  <= item_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_coil_level = level_r;
  assign out_data_bit   = dbit_r;
  assign out_bad_char   = bad_r;
  assign out_run_end    = rend_r;

  assign stat.active  = active_r;
  assign stat.ph_end  = ph_r;
  assign stat.half    = half_r;
  assign stat.bit_idx = bit_r;

endmodule

// ===== sv/magstripe_track_f2f_encoder.sv =====
// ----------------------------------------------------------------------------
// magstripe_track_f2f_encoder
// Maps ASCII characters to track codes and drives them out as F2F half cells.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      valid / stall      character, first_char, last_char
//   out_     output     valid / stall      coil_level, data_bit, bad_char, run_end
//   cfg_     input      valid / ready      track_select
//
// The serializer sets the rate: one half cell per cycle while codes are queued
// and the output is not stalled. A character makes 14 half cells on track one,
// 10 on track two, twice that when the end sentinel follows. A queue of
// QUEUE_DEPTH entries lets the input side run ahead. Reset clears the coil level,
// track_select and queue. A stall on the output holds the serializer; the input
// stalls only when the queue is full. The configuration port is always ready.
// ----------------------------------------------------------------------------
module magstripe_track_f2f_encoder #(
  parameter int QUEUE_DEPTH = mstf2f_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mstf2f_pkg::CHAR_W-1:0] in_character,
  input  logic                          in_first_char,
  input  logic                          in_last_char,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_coil_level,
  output logic                          out_data_bit,
  output logic                          out_bad_char,
  output logic                          out_run_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_track_select
);
  import mstf2f_pkg::*;

  logic          track_r;
  logic          q_wr, q_rd;
  mstf2f_entry_t q_wdata, q_rdata;
  mstf2f_qstat_t q_stat;
  mstf2f_bstat_t b_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      track_r <= cfg_track_select;
    end
  end

  mstf2f_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_character  (in_character),
    .in_first_char (in_first_char),
    .in_last_char  (in_last_char),
    .track_two     (track_r),
    .q_stat        (q_stat),
    .q_wr          (q_wr),
    .q_wdata       (q_wdata)
  );

  mstf2f_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  mstf2f_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_rdata        (q_rdata),
    .q_stat         (q_stat),
    .q_rd           (q_rd),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_coil_level (out_coil_level),
    .out_data_bit   (out_data_bit),
    .out_bad_char   (out_bad_char),
    .out_run_end    (out_run_end),
    .stat           (b_stat)
  );

  // The queue can never report full and empty at once.
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // A half cell that does not close its transaction is followed by another.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_run_end) |=> out_valid)
    else $error("half cell sequence broke off before its run end");

  // An idle serializer sits at the start of a code.
  a_idle_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    !b_stat.active |-> (!b_stat.half && !b_stat.ph_end && b_stat.bit_idx == '0))
    else $error("serializer counters not cleared while idle");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the magnetic stripe F2F track encoder.
//
// Characters go in through the valid/stall input channel and every half cell
// that comes out is checked against a behavioral model of the track tables,
// the start and end sentinels and the F2F coil toggling. Directed tables on
// both tracks come first, then random card records with noise, random gaps
// on both sides and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import mstf2f_pkg::*;

  typedef enum logic {TRACK_ONE = 1'b0, TRACK_TWO = 1'b1} track_e;

  typedef struct packed {
    logic coil;
    logic dbit;
    logic bad;
    logic run_end;
  } half_cell_t;

  localparam logic [6:0] SENT_START_ONE = 7'h45;
  localparam logic [6:0] SENT_START_TWO = 7'h1A;
  localparam logic [6:0] SENT_END       = 7'h1F;
  localparam int         BITS_ONE       = 7;
  localparam int         BITS_TWO       = 5;
  localparam int         RANDOM_ITEMS   = 300;
  localparam int         RANDOM_PHASES  = 6;
  localparam int         HOLD_CYCLES    = 200;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         MAX_REPORTS    = 10;
  localparam int         LIMIT_CYCLES   = 2000000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CHAR_W-1:0]   in_character;
  logic                in_first_char;
  logic                in_last_char;
  logic                out_valid;
  logic                out_stall;
  logic                out_coil_level;
  logic                out_data_bit;
  logic                out_bad_char;
  logic                out_run_end;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_track_select;

  // Model state and scoreboard.
  track_e     track_m = TRACK_ONE;
  logic       coil_m = 1'b0;
  half_cell_t cells_due[$];

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req = 1'b0;

  int items_sent = 0;
  int bad_items = 0;
  int cells_checked = 0;
  int mismatches = 0;

  magstripe_track_f2f_encoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_character     (in_character),
    .in_first_char    (in_first_char),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_coil_level   (out_coil_level),
    .out_data_bit     (out_data_bit),
    .out_bad_char     (out_bad_char),
    .out_run_end      (out_run_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_track_select (cfg_track_select)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Track one covers space through underscore: six bits of offset from space
  // with an odd parity bit on top. Track two only knows digits and a few
  // control characters, stored bit reversed.
  function automatic logic [6:0] char_code(track_e trk, logic [6:0] ch);
    logic [5:0] offs;
    logic [6:0] code;
    code = '0;
    if (trk == TRACK_ONE) begin
      if (ch >= 7'h20 && ch <= 7'h5F) begin
        offs = 6'(ch - 7'h20);
        code = {~^offs, offs};
      end
    end else begin
      case (ch)
        7'h30: code = 7'h01;
        7'h31: code = 7'h10;
        7'h32: code = 7'h08;
        7'h33: code = 7'h19;
        7'h34: code = 7'h04;
        7'h35: code = 7'h15;
        7'h36: code = 7'h0D;
        7'h37: code = 7'h1C;
        7'h38: code = 7'h02;
        7'h39: code = 7'h13;
        7'h3B: code = 7'h1A;
        7'h3D: code = 7'h16;
        7'h3F: code = 7'h1F;
        default: code = '0;
      endcase
    end
    return code;
  endfunction

  function automatic void predict_char(logic [6:0] ch, logic first, logic last);
    logic [6:0] codes [2];
    logic       bad;
    int         nbits;
    int         ncodes;
    half_cell_t hc;
    nbits = (track_m == TRACK_TWO) ? BITS_TWO : BITS_ONE;
    ncodes = last ? 2 : 1;
    bad = 1'b0;
    if (first) begin
      codes[0] = (track_m == TRACK_TWO) ? SENT_START_TWO : SENT_START_ONE;
    end else begin
      codes[0] = char_code(track_m, ch);
      bad = (codes[0] == '0);
    end
    codes[1] = SENT_END;
    if (bad) bad_items++;
    for (int k = 0; k < ncodes; k++) begin
      for (int j = 0; j < nbits; j++) begin
        for (int h = 0; h < 2; h++) begin
          hc.dbit = codes[k][j];
          // The coil flips at every cell boundary and once more mid-cell for a one.
          if (h == 0 || hc.dbit) coil_m = ~coil_m;
          hc.coil = coil_m;
          hc.bad = (k == 0) ? bad : 1'b0;
          hc.run_end = (k == ncodes - 1 && j == nbits - 1 && h == 1);
          cells_due.push_back(hc);
        end
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [6:0] pick_char(track_e trk);
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
    if (trk == TRACK_TWO) return 7'($urandom_range(7'h30, 7'h3F));
    return 7'($urandom_range(7'h20, 7'h5F));
  endfunction

  // Leaves in_valid high on return so that back-to-back transactions keep it up.
  task automatic send_char(logic [6:0] ch, logic first, logic last);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_character <= ch;
    in_first_char <= first;
    in_last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_char(ch, first, last);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_track(track_e trk);
    cfg_valid <= 1'b1;
    cfg_track_select <= trk;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    track_m = trk;
  endtask

  // Runs on the reset value of track_select.
  task automatic test_track_one_table();
    send_char(7'h41, 1'b1, 1'b0);
    send_char(7'h20, 1'b0, 1'b0);
    send_char(7'h5F, 1'b0, 1'b0);
    send_char(7'h35, 1'b0, 1'b0);
    send_char(7'h00, 1'b0, 1'b0);
    send_char(7'h7F, 1'b0, 1'b0);
    send_char(7'h1F, 1'b0, 1'b0);
    send_char(7'h60, 1'b0, 1'b0);
    send_char(7'h5A, 1'b0, 1'b1);
    send_char(7'h7F, 1'b1, 1'b1);
    send_char(7'h00, 1'b0, 1'b1);
    drain();
  endtask

  task automatic test_track_two_table();
    write_track(TRACK_TWO);
    send_char(7'h00, 1'b1, 1'b0);
    send_char(7'h30, 1'b0, 1'b0);
    send_char(7'h33, 1'b0, 1'b0);
    send_char(7'h37, 1'b0, 1'b0);
    send_char(7'h39, 1'b0, 1'b0);
    send_char(7'h3B, 1'b0, 1'b0);
    send_char(7'h3D, 1'b0, 1'b0);
    send_char(7'h3F, 1'b0, 1'b0);
    send_char(7'h3A, 1'b0, 1'b0);
    send_char(7'h7F, 1'b0, 1'b1);
    send_char(7'h31, 1'b1, 1'b1);
    send_char(7'h31, 1'b0, 1'b1);
    drain();
  endtask

  // Mostly well-formed records (start, characters, end) with some loose
  // characters carrying random flags. The first phase runs without gaps.
  task automatic test_random_records();
    int stop_at;
    int len;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_track(track_e'(p[0]));
      tx_idle_en = (p != 0);
      rx_idle_en = (p != 0);
      stop_at = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 99) < 15) begin
          send_char(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end else begin
          len = $urandom_range(0, 6);
          send_char(7'($urandom_range(0, 127)), 1'b1, len == 0);
          for (int i = 1; i <= len; i++) send_char(pick_char(track_m), 1'b0, i == len);
        end
      end
      drain();
    end
  endtask

  // The receiver holds off while characters keep coming, so the queue fills
  // and the input channel has to stall.
  task automatic test_output_backpressure();
    write_track(TRACK_ONE);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    hold_req = 1'b1;
    repeat (16) begin
      send_char(pick_char(track_m), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  initial begin : rx_throttle
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        n = 1 + pick_gap();
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_cell
    half_cell_t got;
    half_cell_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.coil = out_coil_level;
      got.dbit = out_data_bit;
      got.bad = out_bad_char;
      got.run_end = out_run_end;
      cells_checked++;
      if (cells_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] unexpected half cell: coil=%b bit=%b bad=%b end=%b",
                   $time, got.coil, got.dbit, got.bad, got.run_end);
        end
      end else begin
        want = cells_due.pop_front();
        if (got.coil !== want.coil || got.dbit !== want.dbit ||
            got.bad !== want.bad || got.run_end !== want.run_end) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $write("[%0t] half cell %0d: expected coil=%b bit=%b bad=%b end=%b,",
                   $time, cells_checked, want.coil, want.dbit, want.bad, want.run_end);
            $display(" got coil=%b bit=%b bad=%b end=%b",
                     got.coil, got.dbit, got.bad, got.run_end);
          end
        end
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("Timeout with %0d half cells outstanding", cells_due.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_character <= '0;
    in_first_char <= 1'b0;
    in_last_char <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_track_select <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_track_one_table();
    test_track_two_table();
    test_random_records();
    test_output_backpressure();

    $display("Sent %0d characters on both tracks (%0d unmapped), with gaps and a long hold-off",
             items_sent, bad_items);
    $display("Checked %0d half cells, %0d mismatches", cells_checked, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
